FILE: hdl/tdfzc_pkg.sv
// Shared types and constants for the triac dimmer and fan zero-cross sequencer.
`default_nettype none

package tdfzc_pkg;

	localparam int unsigned LEVEL_W = 10;
	localparam int unsigned STEP_W  = 8;
	localparam int unsigned FAN_W   = 3;
	localparam int unsigned KICK_W  = 8;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned SUM_W   = 18;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned ADDR_W  = 5;

	localparam logic [LEVEL_W-1:0] DUTY1_RST     = LEVEL_W'(700);
	localparam logic [LEVEL_W-1:0] DUTY2_RST     = LEVEL_W'(535);
	localparam logic [LEVEL_W-1:0] DUTY3_RST     = LEVEL_W'(365);
	localparam logic [STEP_W-1:0]  RAMP_STEP_RST = STEP_W'(5);
	localparam logic [STEP_W-1:0]  LIGHT_MIN_RST = STEP_W'(10);
	localparam logic [LEVEL_W-1:0] DUTY_IDLE     = LEVEL_W'(1000);
	localparam logic [LEVEL_W-1:0] LIGHT_MAX     = LEVEL_W'(1000);
	localparam logic [FAN_W-1:0]   FAN_MAX       = FAN_W'(4);

	localparam logic [COUNT_W-1:0] SUM_FIRST  = COUNT_W'(21);
	localparam logic [COUNT_W-1:0] SUM_LAST   = COUNT_W'(24);
	localparam logic [COUNT_W-1:0] DECIDE_CNT = COUNT_W'(25);

	localparam logic [TICK_W-1:0] AVG60_LO = TICK_W'(195);
	localparam logic [TICK_W-1:0] AVG60_HI = TICK_W'(205);
	localparam logic [TICK_W-1:0] AVG50_LO = TICK_W'(235);
	localparam logic [TICK_W-1:0] AVG50_HI = TICK_W'(245);

	localparam logic [KICK_W-1:0] KICK_50HZ = KICK_W'(50 * 4);
	localparam logic [KICK_W-1:0] KICK_60HZ = KICK_W'(60 * 4);

	typedef enum logic [1:0] {
		OP_CROSSING = 2'd0,
		OP_LIGHT    = 2'd1,
		OP_FAN      = 2'd2,
		OP_TIMEOUT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_DETECT = 2'd0,
		MODE_WORK   = 2'd1,
		MODE_ERROR  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		FREQ_UNKNOWN = 2'd0,
		FREQ_50HZ    = 2'd1,
		FREQ_60HZ    = 2'd2
	} freq_t;

	typedef enum logic [2:0] {
		REG_DUTY1     = 3'd0,
		REG_DUTY2     = 3'd1,
		REG_DUTY3     = 3'd2,
		REG_RAMP_STEP = 3'd3,
		REG_LIGHT_MIN = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] duty1;
		logic [LEVEL_W-1:0] duty2;
		logic [LEVEL_W-1:0] duty3;
		logic [STEP_W-1:0]  ramp_step;
		logic [STEP_W-1:0]  light_min;
	} cfg_t;

endpackage

`default_nettype wire

FILE: hdl/tdfzc_regs.sv
// APB configuration registers for the sequencer.
`default_nettype none

module tdfzc_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tdfzc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	output tdfzc_pkg::cfg_t                   cfg
);

	tdfzc_pkg::cfg_t      cfg_q;
	tdfzc_pkg::reg_idx_t  idx;
	logic                 wr_en;

	assign idx    = tdfzc_pkg::reg_idx_t'(paddr[tdfzc_pkg::ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty1     <= tdfzc_pkg::DUTY1_RST;
			cfg_q.duty2     <= tdfzc_pkg::DUTY2_RST;
			cfg_q.duty3     <= tdfzc_pkg::DUTY3_RST;
			cfg_q.ramp_step <= tdfzc_pkg::RAMP_STEP_RST;
			cfg_q.light_min <= tdfzc_pkg::LIGHT_MIN_RST;
		end else if (wr_en) begin
			unique case (idx)
				tdfzc_pkg::REG_DUTY1:     cfg_q.duty1     <= pwdata[tdfzc_pkg::LEVEL_W-1:0];
				tdfzc_pkg::REG_DUTY2:     cfg_q.duty2     <= pwdata[tdfzc_pkg::LEVEL_W-1:0];
				tdfzc_pkg::REG_DUTY3:     cfg_q.duty3     <= pwdata[tdfzc_pkg::LEVEL_W-1:0];
				tdfzc_pkg::REG_RAMP_STEP: cfg_q.ramp_step <= pwdata[tdfzc_pkg::STEP_W-1:0];
				tdfzc_pkg::REG_LIGHT_MIN: cfg_q.light_min <= pwdata[tdfzc_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			tdfzc_pkg::REG_DUTY1:     prdata = 32'(cfg_q.duty1);
			tdfzc_pkg::REG_DUTY2:     prdata = 32'(cfg_q.duty2);
			tdfzc_pkg::REG_DUTY3:     prdata = 32'(cfg_q.duty3);
			tdfzc_pkg::REG_RAMP_STEP: prdata = 32'(cfg_q.ramp_step);
			tdfzc_pkg::REG_LIGHT_MIN: prdata = 32'(cfg_q.light_min);
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/triac_dimmer_fan_zero_cross_sequencer.sv
// Top level: zero-cross driven light dimmer and fan sequencer with output register.
//
// Input stream (s_axis_*): one event per transfer; tuser carries the event kind
// (zero crossing, set light target, set fan target, timeout), tdata carries the
// half-wave tick count and the target. Output stream (m_axis_*): one status
// word per accepted event, reflecting the state after that event.
// After reset the block counts 25 crossings to detect the line frequency, then
// enters working mode (or error mode on a bad average); a timeout event returns
// it to detection. Configuration registers sit on an APB port; the user must write
// them only while no event is in flight, and the block itself does not enforce it.
// The status word is registered and appears in the cycle after its event is accepted.
// Throughput: one event per cycle while the receiver keeps taking status words; the
// state update is a single pass through the next-state logic between the state registers.
// Reset clears all state and empties the output register; the config registers
// return to their defaults. When the receiver stalls, the held status word
// stays on m_axis_tdata and s_axis_tready drops until it is taken, except in
// the cycle it is taken, when a new event is accepted alongside.
`default_nettype none

module triac_dimmer_fan_zero_cross_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	// event stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [15:0] half_wave_ticks, [25:16] target, rest 0
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
	// status stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata    // [1:0] mode, [3:2] line_freq,
	                                         // [13:4] light_compare, [14] light_enable,
	                                         // [24:15] fan_compare, [25] fan_enable,
	                                         // [26] fan_kicking, rest 0
);

	localparam int unsigned LW = tdfzc_pkg::LEVEL_W;
	localparam int unsigned FW = tdfzc_pkg::FAN_W;
	localparam int unsigned KW = tdfzc_pkg::KICK_W;
	localparam int unsigned CW = tdfzc_pkg::COUNT_W;
	localparam int unsigned MW = tdfzc_pkg::SUM_W;
	localparam int unsigned TW = tdfzc_pkg::TICK_W;

	tdfzc_pkg::cfg_t cfg;

	tdfzc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// state
	tdfzc_pkg::mode_t run_mode_q, run_mode_d;
	tdfzc_pkg::freq_t freq_q, freq_d;
	logic [CW-1:0]    count_q, count_d;
	logic [MW-1:0]    sum_q, sum_d;
	logic [LW-1:0]    lvl_q, lvl_d;
	logic [LW-1:0]    lgoal_q, lgoal_d;
	logic             lon_q, lon_d;
	logic [FW-1:0]    flvl_q, flvl_d;
	logic [FW-1:0]    fgoal_q, fgoal_d;
	logic [KW-1:0]    kick_q, kick_d;
	logic [LW-1:0]    fduty_q, fduty_d;
	logic             fon_q, fon_d;

	// output register
	logic             out_valid_q;
	logic [31:0]      out_data_q;

	tdfzc_pkg::op_t   op;
	logic [TW-1:0]    ticks;
	logic [LW-1:0]    target;
	logic             accept;

	assign op     = tdfzc_pkg::op_t'(s_axis_tuser);
	assign ticks  = s_axis_tdata[TW-1:0];
	assign target = s_axis_tdata[TW+LW-1:TW];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// detect-mode helpers
	logic [CW-1:0] cnt_inc;
	logic [TW-1:0] avg;

	// light ramp helpers
	logic [LW:0]   lvl_up;
	logic [LW:0]   goal_plus;
	logic [LW-1:0] lvl_r1, lvl_r2;
	logic          lon_r1;
	logic [LW-1:0] min_ext;

	// fan helpers
	logic [FW-1:0] fl_a;
	logic [KW-1:0] kick_a, kick_b;
	logic [LW-1:0] duty_a, duty_b;
	logic          fon_a, fon_b;
	logic [FW-1:0] fl_b;
	logic [LW-1:0] goal_duty;

	function automatic logic [LW-1:0] duty_for(input logic [FW-1:0] spd,
	                                           input tdfzc_pkg::cfg_t c);
		logic [LW-1:0] d;
		d = '0;
		if (spd == FW'(1))
			d = c.duty1;
		else if (spd == FW'(2))
			d = c.duty2;
		else if (spd == FW'(3))
			d = c.duty3;
		return d;
	endfunction

	always_comb begin
		cnt_inc = (count_q < tdfzc_pkg::DECIDE_CNT) ? count_q + CW'(1) : count_q;
		avg     = sum_q[MW-1:2];

		// light: rise toward goal, then fall if over it
		min_ext   = LW'(cfg.light_min);
		lvl_up    = {1'b0, lvl_q} + (LW+1)'(cfg.ramp_step);
		lvl_r1    = lvl_q;
		lon_r1    = lon_q;
		if (lvl_q < lgoal_q) begin
			if (lvl_q < min_ext) begin
				lvl_r1 = min_ext;
				lon_r1 = 1'b1;
			end else if (lvl_up > {1'b0, lgoal_q}) begin
				lvl_r1 = lgoal_q;
			end else begin
				lvl_r1 = lvl_up[LW-1:0];
			end
		end
		goal_plus = {1'b0, lgoal_q} + (LW+1)'(cfg.ramp_step);
		lvl_r2    = lvl_r1;
		lon_d     = lon_r1;
		if (lvl_r1 > lgoal_q) begin
			if ({1'b0, lvl_r1} < goal_plus)
				lvl_r2 = lgoal_q;
			else
				lvl_r2 = lvl_r1 - LW'(cfg.ramp_step);
			if (lvl_r2 < min_ext) begin
				lvl_r2 = '0;
				lon_d  = 1'b0;
			end
		end

		// fan: start kick from standstill, then settle to the goal speed
		fl_a      = flvl_q;
		kick_a    = kick_q;
		duty_a    = fduty_q;
		fon_a     = fon_q;
		fl_b      = flvl_q;
		duty_b    = fduty_q;
		fon_b     = fon_q;
		goal_duty = duty_for(fgoal_q, cfg);
		if (fgoal_q != flvl_q) begin
			if (flvl_q == '0) begin
				kick_a = (freq_q == tdfzc_pkg::FREQ_60HZ) ? tdfzc_pkg::KICK_60HZ
				                                           : tdfzc_pkg::KICK_50HZ;
				fl_a   = tdfzc_pkg::FAN_MAX;
				duty_a = duty_for(tdfzc_pkg::FAN_MAX, cfg);
				fon_a  = 1'b1;
			end
			fl_b   = fl_a;
			duty_b = duty_a;
			fon_b  = fon_a;
			if (kick_a == '0) begin
				fl_b = fgoal_q;
				if (fgoal_q == '0)
					fon_b = 1'b0;
				else
					duty_b = goal_duty;
			end
		end
		kick_b = (kick_a != '0) ? kick_a - KW'(1) : kick_a;

		run_mode_d = run_mode_q;
		freq_d     = freq_q;
		count_d    = count_q;
		sum_d      = sum_q;
		lvl_d      = lvl_q;
		lgoal_d    = lgoal_q;
		flvl_d     = flvl_q;
		fgoal_d    = fgoal_q;
		kick_d     = kick_q;
		fduty_d    = fduty_q;
		fon_d      = fon_q;
		if (!(op == tdfzc_pkg::OP_CROSSING && run_mode_q == tdfzc_pkg::MODE_WORK))
			lon_d = lon_q;

		unique case (op)
			tdfzc_pkg::OP_CROSSING: begin
				if (run_mode_q == tdfzc_pkg::MODE_DETECT) begin
					count_d = cnt_inc;
					if (cnt_inc >= tdfzc_pkg::SUM_FIRST && cnt_inc <= tdfzc_pkg::SUM_LAST)
						sum_d = sum_q + MW'(ticks);
					if (cnt_inc == tdfzc_pkg::DECIDE_CNT) begin
						if (avg > tdfzc_pkg::AVG60_LO && avg < tdfzc_pkg::AVG60_HI) begin
							freq_d     = tdfzc_pkg::FREQ_60HZ;
							run_mode_d = tdfzc_pkg::MODE_WORK;
						end else if (avg > tdfzc_pkg::AVG50_LO && avg < tdfzc_pkg::AVG50_HI) begin
							freq_d     = tdfzc_pkg::FREQ_50HZ;
							run_mode_d = tdfzc_pkg::MODE_WORK;
						end else begin
							run_mode_d = tdfzc_pkg::MODE_ERROR;
						end
					end
				end else if (run_mode_q == tdfzc_pkg::MODE_WORK) begin
					lvl_d   = lvl_r2;
					flvl_d  = fl_b;
					kick_d  = kick_b;
					fduty_d = duty_b;
					fon_d   = fon_b;
				end
			end
			tdfzc_pkg::OP_LIGHT: begin
				if (run_mode_q == tdfzc_pkg::MODE_WORK)
					lgoal_d = (target > tdfzc_pkg::LIGHT_MAX) ? tdfzc_pkg::LIGHT_MAX : target;
			end
			tdfzc_pkg::OP_FAN: begin
				if (run_mode_q == tdfzc_pkg::MODE_WORK) begin
					if (target > LW'(tdfzc_pkg::FAN_MAX))
						fgoal_d = tdfzc_pkg::FAN_MAX;
					else
						fgoal_d = target[FW-1:0];
					if (target == '0)
						kick_d = '0;
				end
			end
			tdfzc_pkg::OP_TIMEOUT: begin
				run_mode_d = tdfzc_pkg::MODE_DETECT;
				freq_d     = tdfzc_pkg::FREQ_UNKNOWN;
				count_d    = '0;
				sum_d      = '0;
				lvl_d      = '0;
				lgoal_d    = '0;
				lon_d      = 1'b0;
				flvl_d     = '0;
				fgoal_d    = '0;
				kick_d     = '0;
				fduty_d    = tdfzc_pkg::DUTY_IDLE;
				fon_d      = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_mode_q <= tdfzc_pkg::MODE_DETECT;
			freq_q     <= tdfzc_pkg::FREQ_UNKNOWN;
			count_q    <= '0;
			sum_q      <= '0;
			lvl_q      <= '0;
			lgoal_q    <= '0;
			lon_q      <= 1'b0;
			flvl_q     <= '0;
			fgoal_q    <= '0;
			kick_q     <= '0;
			fduty_q    <= tdfzc_pkg::DUTY_IDLE;
			fon_q      <= 1'b0;
		end else if (accept) begin
			run_mode_q <= run_mode_d;
			freq_q     <= freq_d;
			count_q    <= count_d;
			sum_q      <= sum_d;
			lvl_q      <= lvl_d;
			lgoal_q    <= lgoal_d;
			lon_q      <= lon_d;
			flvl_q     <= flvl_d;
			fgoal_q    <= fgoal_d;
			kick_q     <= kick_d;
			fduty_q    <= fduty_d;
			fon_q      <= fon_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {5'b0, (kick_d != '0), fon_d, fduty_d, lon_d, lvl_d,
			               freq_d, run_mode_d};
		end
	end

	// an accepted event always shows up on the status stream next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
	else $error("status word missing after accepted event");

	// a running kick countdown implies the fan channel is on
	assert property (@(posedge clk) disable iff (!arst_n)
		kick_q != '0 |-> fon_q)
	else $error("fan kick running with fan channel off");

	// working mode needs a known line frequency
	assert property (@(posedge clk) disable iff (!arst_n)
		run_mode_q == tdfzc_pkg::MODE_WORK |-> freq_q != tdfzc_pkg::FREQ_UNKNOWN)
	else $error("working mode without line frequency");

	// error mode never carries a frequency
	assert property (@(posedge clk) disable iff (!arst_n)
		run_mode_q == tdfzc_pkg::MODE_ERROR |-> freq_q == tdfzc_pkg::FREQ_UNKNOWN)
	else $error("error mode with line frequency set");

	// crossing count saturates at the decision point
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tdfzc_pkg::DECIDE_CNT)
	else $error("crossing count past saturation");

endmodule

`default_nettype wire
